// File: sv/msf_pkg.sv
// Shared types and constants for the mean shift pixel filter.
// Used by the top level, front, queue and back; depends on nothing.
package msf_pkg;

	// Coordinate width of the item port
	localparam int COORD_W = 7;
	// Signed width for window positions and clamped frame sizes
	localparam int POS_W = 14;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_FRAME_WIDTH     = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_SPATIAL_RADIUS  = 3'd2;
	localparam logic [2:0] REG_COLOR_RADIUS    = 3'd3;
	localparam logic [2:0] REG_ITERATION_LIMIT = 3'd4;

	// Item kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_FILTER = 1'b1;

	// Filter request handed from the front to the back
	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} msf_item_t;

	// Status the front needs before it may commit a pixel write
	typedef struct packed {
		logic q_full;
		logic q_empty;
		logic back_busy;
	} msf_ctrl_t;

endpackage

// File: sv/mean_shift_pixel_filter_core.sv
// Mean shift pixel filter top level: configuration registers, front, queue, store, back.
// Depends on msf_pkg, msf_front, msf_queue, msf_ram and msf_back.
//
// A write item stores one pixel and retires once no filter request is pending. A filter
// item runs at most iteration_limit+1 passes over the window of radius R, and its result
// may wait on result_ready; the match count is 9 bits wide at MAX_RADIUS 8. The window
// scan reads one store pixel per cycle through the single read port, and the mean of each
// color channel comes from a shared bit-serial divider. A request outside the frame in
// use goes straight to the result register and returns black. Two filter requests can
// wait in the queue while one is being worked on.
module mean_shift_pixel_filter_core #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_RADIUS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        kind,
	input  logic [6:0]  col,
	input  logic [6:0]  row,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  red_in,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  blue_out,
	output logic [7:0]  green_out,
	output logic [7:0]  red_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

	logic [7:0] fw_q, fh_q, cr_q, lim_q;
	logic [3:0] sr_q;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// Register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= 8'd128;
			fh_q  <= 8'd128;
			sr_q  <= 4'd2;
			cr_q  <= 8'd16;
			lim_q <= 8'd4;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				msf_pkg::REG_FRAME_WIDTH:     fw_q  <= pwdata[7:0];
				msf_pkg::REG_FRAME_HEIGHT:    fh_q  <= pwdata[7:0];
				msf_pkg::REG_SPATIAL_RADIUS:  sr_q  <= pwdata[3:0];
				msf_pkg::REG_COLOR_RADIUS:    cr_q  <= pwdata[7:0];
				msf_pkg::REG_ITERATION_LIMIT: lim_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register read mux
	always_comb begin
		unique case (reg_idx)
			msf_pkg::REG_FRAME_WIDTH:     prdata = {24'd0, fw_q};
			msf_pkg::REG_FRAME_HEIGHT:    prdata = {24'd0, fh_q};
			msf_pkg::REG_SPATIAL_RADIUS:  prdata = {28'd0, sr_q};
			msf_pkg::REG_COLOR_RADIUS:    prdata = {24'd0, cr_q};
			msf_pkg::REG_ITERATION_LIMIT: prdata = {24'd0, lim_q};
			default:                      prdata = 32'd0;
		endcase
	end

	msf_pkg::msf_ctrl_t ctrl;
	msf_pkg::msf_item_t push_item, head;
	logic               push, pop, q_full, q_empty, back_busy;
	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [23:0]        wdata, rdata;

	assign ctrl.q_full    = q_full;
	assign ctrl.q_empty   = q_empty;
	assign ctrl.back_busy = back_busy;

	msf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.kind      (kind),
		.col       (col),
		.row       (row),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.ctrl      (ctrl),
		.push      (push),
		.push_item (push_item),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata)
	);

	msf_queue #(
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	msf_ram #(
		.WIDTH(24),
		.DEPTH(MAX_WIDTH * MAX_HEIGHT)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	msf_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_RADIUS(MAX_RADIUS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_width    (fw_q),
		.frame_height   (fh_q),
		.spatial_radius (sr_q),
		.color_radius   (cr_q),
		.iteration_limit(lim_q),
		.q_valid        (!q_empty),
		.q_item         (head),
		.pop            (pop),
		.busy           (back_busy),
		.raddr          (raddr),
		.rdata          (rdata),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.blue_out       (blue_out),
		.green_out      (green_out),
		.red_out        (red_out)
	);

endmodule

// File: sv/msf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; holds the frame store.
module msf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/msf_queue.sv
// Short request queue between the front and the back of the filter.
// Depends on msf_pkg for the item type.
module msf_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  msf_pkg::msf_item_t push_item,
	input  logic               pop,
	output msf_pkg::msf_item_t head,
	output logic               full,
	output logic               empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	msf_pkg::msf_item_t slot_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/msf_front.sv
// Front of the filter: accepts items, commits pixel writes, queues filter requests.
// Depends on msf_pkg.
module msf_front #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic                                  kind,
	input  logic [msf_pkg::COORD_W-1:0]           col,
	input  logic [msf_pkg::COORD_W-1:0]           row,
	input  logic [7:0]                            blue_in,
	input  logic [7:0]                            green_in,
	input  logic [7:0]                            red_in,
	input  msf_pkg::msf_ctrl_t                    ctrl,
	output logic                                  push,
	output msf_pkg::msf_item_t                    push_item,
	output logic                                  we,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] waddr,
	output logic [23:0]                           wdata
);

	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

	logic                        hv_q;
	logic                        kind_q;
	logic [msf_pkg::COORD_W-1:0] col_q, row_q;
	logic [23:0]                 px_q;
	logic                        retire;

	// Retire the held item: a filter needs queue room, a write waits for the back to drain
	always_comb begin
		retire = 1'b0;
		if (hv_q) begin
			if (kind_q == msf_pkg::KIND_FILTER) begin
				retire = !ctrl.q_full;
			end else begin
				retire = ctrl.q_empty && !ctrl.back_busy;
			end
		end
	end

	assign item_ready     = !hv_q || retire;
	assign push           = retire && (kind_q == msf_pkg::KIND_FILTER);
	assign push_item.col  = col_q;
	assign push_item.row  = row_q;
	assign we             = retire && (kind_q == msf_pkg::KIND_WRITE)
				&& (32'(col_q) < MAX_WIDTH) && (32'(row_q) < MAX_HEIGHT);
	assign waddr          = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));
	assign wdata          = px_q;

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			kind_q <= kind;
			col_q  <= col;
			row_q  <= row;
			px_q   <= {red_in, green_in, blue_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			hv_q <= 1'b1;
		end else if (retire) begin
			hv_q <= 1'b0;
		end
	end

endmodule

// File: sv/msf_back.sv
// Back of the filter: mean shift engine with window scan, serial divider and result register.
// Depends on msf_pkg; reads the frame store through a registered RAM port.
module msf_back #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_RADIUS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [7:0]                            frame_width,
	input  logic [7:0]                            frame_height,
	input  logic [3:0]                            spatial_radius,
	input  logic [7:0]                            color_radius,
	input  logic [7:0]                            iteration_limit,
	input  logic                                  q_valid,
	input  msf_pkg::msf_item_t                    q_item,
	output logic                                  pop,
	output logic                                  busy,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] raddr,
	input  logic [23:0]                           rdata,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [7:0]                            blue_out,
	output logic [7:0]                            green_out,
	output logic [7:0]                            red_out
);

	localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int PW     = msf_pkg::POS_W;
	localparam int RW     = $clog2(MAX_RADIUS + 1) + 2;
	localparam int CNT_W  = $clog2((2*MAX_RADIUS + 1) * (2*MAX_RADIUS + 1) + 1);
	localparam int SUM_W  = CNT_W + 8;
	localparam int CW     = 8 + FRAC_BITS;
	localparam int SQ_W   = 2*CW - FRAC_BITS;
	localparam int DIST_W = SQ_W + 2;
	localparam int BND_W  = 16 + FRAC_BITS;
	localparam int CMP_W  = (DIST_W > BND_W) ? DIST_W : BND_W;
	localparam int NUM_W  = SUM_W + FRAC_BITS;
	localparam int DS_W   = $clog2(NUM_W + 1);
	localparam logic [CW-1:0]     HALF        = CW'(1) << (FRAC_BITS - 1);
	localparam logic [DIST_W-1:0] SHIFT_LIMIT = DIST_W'((64'd1 << FRAC_BITS) / 10);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_LOADW = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_DRAIN = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_SHF   = 4'd6;
	localparam logic [3:0] S_UPD   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	// Truncated square of a Q8.F difference
	function automatic logic [SQ_W-1:0] sq_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW-1:0]   m;
		logic [2*CW-1:0] p;
		m = (a > b) ? (a - b) : (b - a);
		p = (2*CW)'(m) * (2*CW)'(m);
		return SQ_W'(p >> FRAC_BITS);
	endfunction

	logic [3:0]                 st_q;
	logic [msf_pkg::COORD_W-1:0] col_q, row_q;
	logic signed [PW-1:0]       fw_q, fh_q;
	logic signed [RW-1:0]       r_q, dx_q, dy_q;
	logic                       zero_q;
	logic [CW-1:0]              cent_q [3];
	logic [CW-1:0]              mean_q [3];
	logic [SUM_W-1:0]           sum_q  [3];
	logic [CNT_W-1:0]           cnt_q;
	logic [8:0]                 pass_q;
	logic [DIST_W-1:0]          shift_q;
	logic [SQ_W-1:0]            sq_q;
	logic                       phase_q;
	logic [1:0]                 ch_q;
	logic [1:0]                 drain_q;
	logic [CNT_W:0]             rem_q;
	logic [NUM_W-1:0]           num_q, quo_q;
	logic [DS_W-1:0]            dstep_q;
	logic                       v_s1, v_s2;
	logic [SQ_W-1:0]            sq_s2 [3];
	logic [7:0]                 px_s2 [3];
	logic                       rv_q;
	logic [7:0]                 b_q, g_q, r_out_q;

	// Clamped configuration for a new request
	logic signed [PW-1:0] fw_new, fh_new;
	logic signed [RW-1:0] r_new;
	always_comb begin
		fw_new = (frame_width == 8'd0) ? PW'(1) : PW'(frame_width);
		if (32'(frame_width) > MAX_WIDTH) begin
			fw_new = PW'(MAX_WIDTH);
		end
		fh_new = (frame_height == 8'd0) ? PW'(1) : PW'(frame_height);
		if (32'(frame_height) > MAX_HEIGHT) begin
			fh_new = PW'(MAX_HEIGHT);
		end
		r_new = (32'(spatial_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(spatial_radius);
	end

	// Window position of the current scan step
	logic signed [PW-1:0]  xi, yi;
	logic signed [2*RW:0]  d2, r2;
	logic                  in_win, scan_last;
	always_comb begin
		xi = PW'(col_q) + PW'(dx_q);
		yi = PW'(row_q) + PW'(dy_q);
		d2 = (2*RW+1)'(dx_q) * (2*RW+1)'(dx_q) + (2*RW+1)'(dy_q) * (2*RW+1)'(dy_q);
		r2 = (2*RW+1)'(r_q) * (2*RW+1)'(r_q);
		in_win = (d2 <= r2) && (xi >= 0) && (yi >= 0) && (xi < fw_q) && (yi < fh_q);
		scan_last = (dx_q == r_q) && (dy_q == r_q);
	end

	// Select the centre pixel or the scan position for the store read
	always_comb begin
		if (st_q == S_LOAD) begin
			raddr = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));
		end else begin
			raddr = AW'(32'(yi) * MAX_WIDTH + 32'(xi));
		end
	end

	// Color distance of the pixel in the second stage
	logic [DIST_W-1:0] cdist;
	logic [BND_W-1:0]  cbound;
	logic              match;
	always_comb begin
		cdist  = DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
		cbound = BND_W'(16'(color_radius) * 16'(color_radius)) << FRAC_BITS;
		match  = v_s2 && (CMP_W'(cdist) <= CMP_W'(cbound));
	end

	// One restoring divider step
	logic [CNT_W:0]   trial;
	logic             qbit;
	logic [CNT_W:0]   rem_nx;
	logic [NUM_W-1:0] quo_nx;
	always_comb begin
		trial  = {rem_q[CNT_W-1:0], num_q[NUM_W-1]};
		qbit   = (trial >= {1'b0, cnt_q});
		rem_nx = qbit ? (trial - {1'b0, cnt_q}) : trial;
		quo_nx = {quo_q[NUM_W-2:0], qbit};
	end

	// Rounded result of the centre
	logic [CW:0] rnd [3];
	logic [7:0]  res [3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rnd[c] = ((CW+1)'(cent_q[c]) + (CW+1)'(HALF)) >> FRAC_BITS;
			res[c] = (rnd[c] > (CW+1)'(255)) ? 8'd255 : rnd[c][7:0];
		end
	end

	assign pop          = (st_q == S_IDLE) && q_valid;
	assign busy         = (st_q != S_IDLE);
	assign result_valid = rv_q;
	assign blue_out     = b_q;
	assign green_out    = g_q;
	assign red_out      = r_out_q;

	// Pixel pipeline and datapath registers
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sq_s2[c] <= sq_diff({rdata[8*c +: 8], FRAC_BITS'(0)}, cent_q[c]);
			px_s2[c] <= rdata[8*c +: 8];
		end
		unique case (st_q)
			S_IDLE: begin
				col_q <= q_item.col;
				row_q <= q_item.row;
				fw_q  <= fw_new;
				fh_q  <= fh_new;
				r_q   <= r_new;
				zero_q <= (PW'(q_item.col) >= fw_new) || (PW'(q_item.row) >= fh_new);
			end
			S_LOAD: begin
			end
			S_LOADW: begin
				for (int c = 0; c < 3; c++) begin
					cent_q[c] <= {rdata[8*c +: 8], FRAC_BITS'(0)};
					sum_q[c]  <= '0;
				end
				cnt_q  <= '0;
				pass_q <= '0;
				dx_q   <= -r_q;
				dy_q   <= -r_q;
			end
			S_SCAN, S_DRAIN: begin
				if (dx_q == r_q) begin
					dx_q <= -r_q;
					if (!scan_last) begin
						dy_q <= dy_q + RW'(1);
					end
				end else begin
					dx_q <= dx_q + RW'(1);
				end
				if (match) begin
					for (int c = 0; c < 3; c++) begin
						sum_q[c] <= sum_q[c] + SUM_W'(px_s2[c]);
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ch_q    <= 2'd0;
				rem_q   <= '0;
				dstep_q <= '0;
				num_q   <= {sum_q[0], FRAC_BITS'(0)};
			end
			S_DIV: begin
				if (dstep_q == DS_W'(NUM_W - 1)) begin
					mean_q[ch_q] <= CW'(quo_nx);
					rem_q   <= '0;
					dstep_q <= '0;
					if (ch_q == 2'd2) begin
						ch_q    <= 2'd0;
						phase_q <= 1'b0;
						shift_q <= '0;
					end else begin
						ch_q  <= ch_q + 2'd1;
						num_q <= {sum_q[ch_q + 2'd1], FRAC_BITS'(0)};
					end
				end else begin
					rem_q   <= rem_nx;
					quo_q   <= quo_nx;
					num_q   <= num_q << 1;
					dstep_q <= dstep_q + DS_W'(1);
				end
			end
			S_SHF: begin
				phase_q <= !phase_q;
				if (!phase_q) begin
					sq_q <= sq_diff(mean_q[ch_q], cent_q[ch_q]);
				end else begin
					shift_q <= shift_q + DIST_W'(sq_q);
					ch_q    <= ch_q + 2'd1;
				end
			end
			S_UPD: begin
				for (int c = 0; c < 3; c++) begin
					cent_q[c] <= mean_q[c];
					sum_q[c]  <= '0;
				end
				cnt_q  <= '0;
				pass_q <= pass_q + 9'd1;
				dx_q   <= -r_q;
				dy_q   <= -r_q;
			end
			S_DONE: begin
				if (!rv_q || result_ready) begin
					b_q     <= zero_q ? 8'd0 : res[0];
					g_q     <= zero_q ? 8'd0 : res[1];
					r_out_q <= zero_q ? 8'd0 : res[2];
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, pipeline valids and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			rv_q    <= 1'b0;
			drain_q <= 2'd0;
		end else begin
			v_s1 <= (st_q == S_SCAN) && in_win;
			v_s2 <= v_s1;
			// Load a new result or drop the one just taken
			if ((st_q == S_DONE) && (!rv_q || result_ready)) begin
				rv_q <= 1'b1;
			end else if (rv_q && result_ready) begin
				rv_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						st_q <= ((PW'(q_item.col) >= fw_new) || (PW'(q_item.row) >= fh_new))
							? S_DONE : S_LOAD;
					end
				end
				S_LOAD:  st_q <= S_LOADW;
				S_LOADW: st_q <= S_SCAN;
				S_SCAN: begin
					drain_q <= 2'd0;
					if (scan_last) begin
						st_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						st_q <= (cnt_q == '0) ? S_DONE : S_DIV;
					end
				end
				S_DIV: begin
					if ((dstep_q == DS_W'(NUM_W - 1)) && (ch_q == 2'd2)) begin
						st_q <= S_SHF;
					end
				end
				S_SHF: begin
					if (phase_q && (ch_q == 2'd2)) begin
						st_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (((pass_q + 9'd1) > {1'b0, iteration_limit}) || (shift_q <= SHIFT_LIMIT)) begin
						st_q <= S_DONE;
					end else begin
						st_q <= S_SCAN;
					end
				end
				S_DONE: begin
					if (!rv_q || result_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/msf_checker.sv
// Port-level checks for the mean shift pixel filter, bound to the top level.
// Depends on mean_shift_pixel_filter_core ports only.
module msf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] blue_out,
	input logic [7:0] green_out,
	input logic [7:0] red_out,
	input logic       pready
);

	// Hold a stalled result transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(blue_out)
			&& $stable(green_out) && $stable(red_out))
		else $error("result changed while stalled");

	// Drop result valid during reset
	assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// Keep the register port always ready
	assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind mean_shift_pixel_filter_core msf_checker u_msf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.blue_out    (blue_out),
	.green_out   (green_out),
	.red_out     (red_out),
	.pready      (pready)
);
